[hdl/cra_pkg.sv]
// ----------------------------------------------------------------------------
// cra_pkg: shared definitions of the contiguous region allocator
// Sizes, codes, table entry layout and the controller/datapath link types.
// ----------------------------------------------------------------------------
package cra_pkg;

	localparam int MAX_REGIONS = 64;
	localparam int ADDR_WIDTH  = 20;
	localparam int IDX_W       = $clog2(MAX_REGIONS);
	localparam int CNT_W       = $clog2(MAX_REGIONS + 1);
	localparam int SIZE_W      = 21;
	localparam int OWNER_W     = 16;

	localparam logic [32:0] ADDR_CAP = 33'(1) << ADDR_WIDTH;
	localparam logic [SIZE_W-1:0] MEM_SIZE_RST = SIZE_W'(1048576);

	localparam logic [1:0] MODE_REQUEST = 2'd0;
	localparam logic [1:0] MODE_RELEASE = 2'd1;
	localparam logic [1:0] MODE_COMPACT = 2'd2;

	localparam logic [1:0] POL_FIRST = 2'd0;
	localparam logic [1:0] POL_BEST  = 2'd1;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NOFIT   = 2'd1,
		ST_NOOWNER = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	typedef struct packed {
		logic [OWNER_W-1:0] owner;
		logic [SIZE_W-1:0]  start_addr;
		logic [SIZE_W-1:0]  end_addr;
	} entry_t;

	typedef enum logic [3:0] {
		DP_NOP,
		DP_LOAD,
		DP_REQ_STEP,
		DP_UP_PREP,
		DP_UP_STEP,
		DP_PLACE,
		DP_REL_STEP,
		DP_DOWN_STEP,
		DP_CNT_DEC,
		DP_CMP_STEP,
		DP_OUT
	} dp_op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_REQ_SCAN,
		S_UP_PREP,
		S_UP,
		S_PLACE,
		S_REL_SCAN,
		S_DOWN,
		S_CMP_SCAN,
		S_FIN
	} state_t;

	typedef struct packed {
		dp_op_t  op;
		logic    res_we;
		status_t res_code;
		logic    res_grant;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] in_mode;
		logic       full;
		logic       last;
		logic       take;
		logic       found_nxt;
		logic       first_fit;
		logic       match;
		logic       pick_eq_cnt;
		logic       up_last;
		logic       down_more;
		logic       slot_free;
	} dp_sts_t;

endpackage

[hdl/cra_ifs.sv]
// ----------------------------------------------------------------------------
// cra_req_if / cra_rsp_if: valid/ready channels of the region allocator
// Request beats carry an operation; response beats carry its outcome.
// ----------------------------------------------------------------------------
interface cra_req_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    mode;
	logic [cra_pkg::OWNER_W-1:0]   owner_id;
	logic [cra_pkg::SIZE_W-1:0]    alloc_size;
	logic [1:0]                    fit_policy;

	modport source (output valid, mode, owner_id, alloc_size, fit_policy, input ready);
	modport sink   (input valid, mode, owner_id, alloc_size, fit_policy, output ready);
endinterface

interface cra_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    status;
	logic [cra_pkg::SIZE_W-1:0]    granted_start;

	modport source (output valid, status, granted_start, input ready);
	modport sink   (input valid, status, granted_start, output ready);
endinterface

[hdl/contiguous_region_allocator_unit.sv]
// Operations: a request scans the table, shifts up the entries above the chosen slot and
// places the region (an early first fit scans less, a miss skips the shift); a release
// scans and shifts down, a compact rewrites each entry; a full-table refusal or a no-op
// goes straight to the response. One beat at a time: the next request can be taken as soon
// as the response beat appears; an operation's final step waits while that beat is unread.
// Reset: arst_n clears the region count, the sequencer and the response valid flag; the
// memory size register returns to 1048576 and the table contents are left as they are.
// ----------------------------------------------------------------------------
// contiguous_region_allocator_unit: top level of the region allocator
// Joins the sequencer and the table datapath to the request, response and
// configuration ports.
// ----------------------------------------------------------------------------
module contiguous_region_allocator_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	cra_req_if.sink                      req,
	cra_rsp_if.source                    rsp,
	input  logic                         cfg_we,
	input  logic [cra_pkg::SIZE_W-1:0]   cfg_wdata
);

	// The sequencer only issues commands; every piece of table state, the
	// scan bookkeeping and the response register live in the datapath.
	cra_pkg::dp_cmd_t cmd;
	cra_pkg::dp_sts_t sts;

	cra_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// The response register lets a new request beat be taken while the last
	// response beat is still waiting on its consumer.
	cra_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.in_mode     (req.mode),
		.in_owner    (req.owner_id),
		.in_size     (req.alloc_size),
		.in_policy   (req.fit_policy),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.out_valid   (rsp.valid),
		.out_ready   (rsp.ready),
		.out_status  (rsp.status),
		.out_granted (rsp.granted_start)
	);

`ifndef SYNTHESIS
	// An accepted beat always moves the sequencer out of idle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request taken while an operation was in flight");

	// Loading the response register ends the operation and shows the beat.
	a_out_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == cra_pkg::DP_OUT |=> req.ready && rsp.valid)
		else $error("response load did not return to idle");

	// A region is never placed into a full table.
	a_no_place_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(sts.full && cmd.op == cra_pkg::DP_PLACE))
		else $error("insert into a full region table");

	// Only a successful request reports a nonzero start.
	a_grant_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status != cra_pkg::ST_OK |-> rsp.granted_start == '0)
		else $error("failed operation reported a granted start");
`endif

endmodule

[hdl/cra_dpath.sv]
// ----------------------------------------------------------------------------
// cra_dpath: region table memory, scan registers and result register
// Executes one controller command per cycle on the address-ordered table.
// ----------------------------------------------------------------------------
module cra_dpath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cra_pkg::dp_cmd_t              cmd,
	output cra_pkg::dp_sts_t              sts,
	input  logic [1:0]                    in_mode,
	input  logic [cra_pkg::OWNER_W-1:0]   in_owner,
	input  logic [cra_pkg::SIZE_W-1:0]    in_size,
	input  logic [1:0]                    in_policy,
	input  logic                          cfg_we,
	input  logic [cra_pkg::SIZE_W-1:0]    cfg_wdata,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    out_status,
	output logic [cra_pkg::SIZE_W-1:0]    out_granted
);

	cra_pkg::entry_t mem_q [cra_pkg::MAX_REGIONS];
	cra_pkg::entry_t rdata_q;

	logic [cra_pkg::SIZE_W-1:0]  mem_size_q;
	logic [cra_pkg::CNT_W-1:0]   cnt_q, i_q, pick_q;
	logic [cra_pkg::SIZE_W-1:0]  prev_end_q, pick_size_q, pick_start_q, next_q;
	logic                        found_q;
	logic [cra_pkg::OWNER_W-1:0] owner_q;
	logic [cra_pkg::SIZE_W-1:0]  size_q;
	logic [1:0]                  pol_q;
	cra_pkg::status_t            res_code_q;
	logic [cra_pkg::SIZE_W-1:0]  res_grant_q;
	logic                        ov_q;
	logic [1:0]                  os_q;
	logic [cra_pkg::SIZE_W-1:0]  og_q;

	logic [cra_pkg::SIZE_W-1:0]  usable, lim, hole, len;
	logic                        fit, better;
	logic [cra_pkg::CNT_W-1:0]   rd_ptr;
	logic                        mem_we;
	logic [cra_pkg::CNT_W-1:0]   wr_ptr;
	cra_pkg::entry_t             wdata;

	assign usable = ({12'd0, mem_size_q} > cra_pkg::ADDR_CAP)
		? cra_pkg::ADDR_CAP[cra_pkg::SIZE_W-1:0] : mem_size_q;
	assign lim    = (i_q < cnt_q) ? rdata_q.start_addr : usable;
	assign hole   = (lim >= prev_end_q) ? lim - prev_end_q : '0;
	assign fit    = size_q <= hole;
	assign better = (pol_q == cra_pkg::POL_BEST) ? (hole < pick_size_q)
		: (pol_q != cra_pkg::POL_FIRST) && (hole > pick_size_q);
	assign len    = rdata_q.end_addr - rdata_q.start_addr;

	always_comb begin
		sts.in_mode     = in_mode;
		sts.full        = cnt_q == cra_pkg::CNT_W'(cra_pkg::MAX_REGIONS);
		sts.last        = i_q == cnt_q;
		sts.take        = fit && (!found_q || better);
		sts.found_nxt   = found_q || fit;
		sts.first_fit   = pol_q == cra_pkg::POL_FIRST;
		sts.match       = rdata_q.owner == owner_q;
		sts.pick_eq_cnt = pick_q == cnt_q;
		sts.up_last     = (i_q - 1'b1) == pick_q;
		sts.down_more   = (i_q + 1'b1) < cnt_q;
		sts.slot_free   = !ov_q || out_ready;
	end

	always_comb begin
		case (cmd.op)
			cra_pkg::DP_LOAD:      rd_ptr = '0;
			cra_pkg::DP_UP_PREP:   rd_ptr = cnt_q - 1'b1;
			cra_pkg::DP_UP_STEP:   rd_ptr = i_q - 2'd2;
			cra_pkg::DP_DOWN_STEP: rd_ptr = i_q + 2'd2;
			default:               rd_ptr = i_q + 1'b1;
		endcase
	end

	always_comb begin
		mem_we = 1'b0;
		wr_ptr = i_q;
		wdata  = rdata_q;
		case (cmd.op)
			cra_pkg::DP_UP_STEP,
			cra_pkg::DP_DOWN_STEP: mem_we = 1'b1;
			cra_pkg::DP_PLACE: begin
				mem_we           = 1'b1;
				wr_ptr           = pick_q;
				wdata.owner      = owner_q;
				wdata.start_addr = pick_start_q;
				wdata.end_addr   = pick_start_q + size_q;
			end
			cra_pkg::DP_CMP_STEP: begin
				mem_we           = 1'b1;
				wdata.start_addr = next_q;
				wdata.end_addr   = next_q + len;
			end
			default: mem_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem_q[wr_ptr[cra_pkg::IDX_W-1:0]] <= wdata;
		rdata_q <= mem_q[rd_ptr[cra_pkg::IDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_size_q <= cra_pkg::MEM_SIZE_RST;
			cnt_q      <= '0;
			ov_q       <= 1'b0;
		end else begin
			if (cfg_we)
				mem_size_q <= cfg_wdata;
			if (cmd.op == cra_pkg::DP_PLACE)
				cnt_q <= cnt_q + 1'b1;
			else if (cmd.op == cra_pkg::DP_CNT_DEC)
				cnt_q <= cnt_q - 1'b1;
			if (cmd.op == cra_pkg::DP_OUT)
				ov_q <= 1'b1;
			else if (out_ready)
				ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			cra_pkg::DP_LOAD: begin
				owner_q    <= in_owner;
				size_q     <= in_size;
				pol_q      <= in_policy;
				i_q        <= '0;
				prev_end_q <= '0;
				next_q     <= '0;
				found_q    <= 1'b0;
			end
			cra_pkg::DP_REQ_STEP: begin
				if (sts.take) begin
					pick_q       <= i_q;
					pick_size_q  <= hole;
					pick_start_q <= prev_end_q;
					found_q      <= 1'b1;
				end
				prev_end_q <= rdata_q.end_addr;
				i_q        <= i_q + 1'b1;
			end
			cra_pkg::DP_UP_PREP:  i_q <= cnt_q;
			cra_pkg::DP_UP_STEP:  i_q <= i_q - 1'b1;
			cra_pkg::DP_REL_STEP,
			cra_pkg::DP_DOWN_STEP: i_q <= i_q + 1'b1;
			cra_pkg::DP_CMP_STEP: begin
				next_q <= next_q + len;
				i_q    <= i_q + 1'b1;
			end
			cra_pkg::DP_OUT: begin
				os_q <= res_code_q;
				og_q <= res_grant_q;
			end
			default: i_q <= i_q;
		endcase
		if (cmd.res_we) begin
			res_code_q  <= cmd.res_code;
			res_grant_q <= cmd.res_grant ? pick_start_q : '0;
		end
	end

	assign out_valid   = ov_q;
	assign out_status  = os_q;
	assign out_granted = og_q;

endmodule

[hdl/cra_ctrl.sv]
// ----------------------------------------------------------------------------
// cra_ctrl: sequencer of the region allocator
// Walks each operation through scan, shift and write-back steps.
// ----------------------------------------------------------------------------
module cra_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  cra_pkg::dp_sts_t  sts,
	output cra_pkg::dp_cmd_t  cmd
);

	cra_pkg::state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= cra_pkg::S_IDLE;
		else
			state_q <= state_nxt;
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			cra_pkg::S_IDLE: begin
				if (in_valid) begin
					case (sts.in_mode)
						cra_pkg::MODE_REQUEST:
							state_nxt = sts.full ? cra_pkg::S_FIN : cra_pkg::S_REQ_SCAN;
						cra_pkg::MODE_RELEASE: state_nxt = cra_pkg::S_REL_SCAN;
						cra_pkg::MODE_COMPACT: state_nxt = cra_pkg::S_CMP_SCAN;
						default:               state_nxt = cra_pkg::S_FIN;
					endcase
				end
			end
			cra_pkg::S_REQ_SCAN: begin
				if ((sts.take && sts.first_fit) || sts.last)
					state_nxt = sts.found_nxt ? cra_pkg::S_UP_PREP : cra_pkg::S_FIN;
			end
			cra_pkg::S_UP_PREP:
				state_nxt = sts.pick_eq_cnt ? cra_pkg::S_PLACE : cra_pkg::S_UP;
			cra_pkg::S_UP:
				if (sts.up_last)
					state_nxt = cra_pkg::S_PLACE;
			cra_pkg::S_PLACE: state_nxt = cra_pkg::S_FIN;
			cra_pkg::S_REL_SCAN: begin
				if (sts.last)
					state_nxt = cra_pkg::S_FIN;
				else if (sts.match)
					state_nxt = cra_pkg::S_DOWN;
			end
			cra_pkg::S_DOWN:
				if (!sts.down_more)
					state_nxt = cra_pkg::S_FIN;
			cra_pkg::S_CMP_SCAN:
				if (sts.last)
					state_nxt = cra_pkg::S_FIN;
			cra_pkg::S_FIN:
				if (sts.slot_free)
					state_nxt = cra_pkg::S_IDLE;
			default: state_nxt = cra_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd.op        = cra_pkg::DP_NOP;
		cmd.res_we    = 1'b0;
		cmd.res_code  = cra_pkg::ST_OK;
		cmd.res_grant = 1'b0;
		in_ready      = 1'b0;
		case (state_q)
			cra_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op     = cra_pkg::DP_LOAD;
					cmd.res_we = 1'b1;
					if (sts.in_mode == cra_pkg::MODE_REQUEST && sts.full)
						cmd.res_code = cra_pkg::ST_FULL;
				end
			end
			cra_pkg::S_REQ_SCAN: begin
				cmd.op = cra_pkg::DP_REQ_STEP;
				if (((sts.take && sts.first_fit) || sts.last) && !sts.found_nxt) begin
					cmd.res_we   = 1'b1;
					cmd.res_code = cra_pkg::ST_NOFIT;
				end
			end
			cra_pkg::S_UP_PREP: cmd.op = cra_pkg::DP_UP_PREP;
			cra_pkg::S_UP:      cmd.op = cra_pkg::DP_UP_STEP;
			cra_pkg::S_PLACE: begin
				cmd.op        = cra_pkg::DP_PLACE;
				cmd.res_we    = 1'b1;
				cmd.res_grant = 1'b1;
			end
			cra_pkg::S_REL_SCAN: begin
				if (sts.last) begin
					cmd.res_we   = 1'b1;
					cmd.res_code = cra_pkg::ST_NOOWNER;
				end else if (!sts.match) begin
					cmd.op = cra_pkg::DP_REL_STEP;
				end
			end
			cra_pkg::S_DOWN: begin
				if (sts.down_more) begin
					cmd.op = cra_pkg::DP_DOWN_STEP;
				end else begin
					cmd.op     = cra_pkg::DP_CNT_DEC;
					cmd.res_we = 1'b1;
				end
			end
			cra_pkg::S_CMP_SCAN: begin
				if (sts.last)
					cmd.res_we = 1'b1;
				else
					cmd.op = cra_pkg::DP_CMP_STEP;
			end
			cra_pkg::S_FIN:
				if (sts.slot_free)
					cmd.op = cra_pkg::DP_OUT;
			default: cmd.op = cra_pkg::DP_NOP;
		endcase
	end

endmodule
